// File: rtl/assert_macros.svh
// Assertion macros for the checker file rccbp_checker.sv.
// Needs signal clk, and rst_n for ASSERT_CLK, in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rccbp_pkg.sv
// Package for the RC command byte parser: types, register indexes, reset codes.
// No dependencies.
package rccbp_pkg;

  localparam int TextLengthDef = 8;
  localparam int KeptChars     = 4;
  localparam int KeptIdxW      = 2;
  localparam int CfgAddrW      = 3;
  localparam int CfgDataW      = 8;
  localparam int AccW          = 14;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  chan_t;
  typedef logic [15:0] value_t;
  typedef logic [CfgAddrW-1:0] cfg_addr_t;

  typedef struct packed {
    byte_t finish;
    byte_t roll;
    byte_t pitch;
    byte_t yaw;
    byte_t throttle;
  } codes_t;

  localparam cfg_addr_t REG_FINISH   = 3'd0;
  localparam cfg_addr_t REG_ROLL     = 3'd1;
  localparam cfg_addr_t REG_PITCH    = 3'd2;
  localparam cfg_addr_t REG_YAW      = 3'd3;
  localparam cfg_addr_t REG_THROTTLE = 3'd4;

  localparam byte_t FINISH_RST   = 8'd10;
  localparam byte_t ROLL_RST     = 8'd82;
  localparam byte_t PITCH_RST    = 8'd80;
  localparam byte_t YAW_RST      = 8'd89;
  localparam byte_t THROTTLE_RST = 8'd84;

  localparam chan_t CH_ROLL     = 2'd0;
  localparam chan_t CH_PITCH    = 2'd1;
  localparam chan_t CH_YAW      = 2'd2;
  localparam chan_t CH_THROTTLE = 2'd3;

  localparam byte_t ASCII_ZERO  = 8'h30;
  localparam byte_t ASCII_NINE  = 8'h39;
  localparam byte_t ASCII_PLUS  = 8'h2B;
  localparam byte_t ASCII_MINUS = 8'h2D;
  localparam byte_t ASCII_NUL   = 8'h00;

  function automatic logic is_blank(input byte_t c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_digit(input byte_t c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

endpackage

// File: rtl/rccbp_if.sv
// Valid/ready channel interfaces for the parser's input and result items.
// Depends on rccbp_pkg.
interface rccbp_in_if import rccbp_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface rccbp_out_if import rccbp_pkg::*; ();
  logic   valid;
  logic   ready;
  chan_t  channel;
  value_t value;

  modport source(output valid, output channel, output value, input ready);
  modport sink(input valid, input channel, input value, output ready);
endinterface

// File: rtl/rccbp_parse.sv
// Decimal parser over the four kept characters: blanks, sign, digits.
// Combinational; depends on rccbp_pkg.
module rccbp_parse import rccbp_pkg::*; (
  input  byte_t  chars [KeptChars],
  output value_t value
);

  logic [AccW-1:0] acc;
  logic            neg;
  logic            in_num;
  logic            done;
  logic [AccW-1:0] acc_abs;

  always_comb begin
    acc    = '0;
    neg    = 1'b0;
    in_num = 1'b0;
    done   = 1'b0;
    for (int i = 0; i < KeptChars; i++) begin
      if (!done) begin
        if (!in_num) begin
          if (is_blank(chars[i])) begin
            in_num = 1'b0;
          end else if (chars[i] == ASCII_PLUS || chars[i] == ASCII_MINUS) begin
            neg    = (chars[i] == ASCII_MINUS);
            in_num = 1'b1;
          end else if (is_digit(chars[i])) begin
            acc    = AccW'(chars[i] - ASCII_ZERO);
            in_num = 1'b1;
          end else begin
            done = 1'b1;
          end
        end else if (is_digit(chars[i])) begin
          acc = AccW'(acc * AccW'(10)) + AccW'(chars[i] - ASCII_ZERO);
        end else begin
          done = 1'b1;
        end
      end
    end
    acc_abs = acc;
  end

  assign value = neg ? (16'd0 - 16'(acc_abs)) : 16'(acc_abs);

endmodule

// File: rtl/rc_command_byte_parser.sv
// RC command byte parser, top level.
// Channels: in_chan carries one received byte per item (rx_byte); out_chan
// carries one result item (channel 0..3 = roll, pitch, yaw, throttle, and a
// 16-bit value). Both use valid/ready; an item moves when both are high.
// cfg_we/cfg_addr/cfg_wdata write the finish and four channel marker codes;
// write only while no item is in flight.
// A marker byte selects its channel and restarts the text; other bytes fill
// up to four kept characters; the finish byte parses them as signed decimal
// and, once a channel has been selected, emits one result item.
// Pipeline: a taken byte is processed from the input register; its result is
// registered and drives out_chan. Throughput: one byte per cycle outside output
// stalls, set by the single input register feeding the single result register.
// Reset: marker codes go to their defaults, text, position and channel
// selection clear, both stages empty.
// Output stall: a held result blocks only a byte that would produce another
// result; marker and text bytes keep flowing. in_chan.ready drops while
// such a byte waits.
// Depends on rccbp_pkg, rccbp_if, rccbp_parse.
module rc_command_byte_parser import rccbp_pkg::*; #(
  parameter int TEXT_LENGTH = TextLengthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rccbp_in_if.sink             in_chan,
  rccbp_out_if.source          out_chan,
  input  logic                 cfg_we,
  input  cfg_addr_t            cfg_addr,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  localparam int PosW = $clog2(TEXT_LENGTH + 3);
  localparam logic [PosW-1:0] PosWrap = PosW'(TEXT_LENGTH + 1);
  localparam logic [PosW-1:0] PosKept = PosW'(KeptChars);

  codes_t          codes_r;
  logic            s1_valid_r;
  byte_t           s1_byte_r;
  byte_t           chars_r   [KeptChars];
  byte_t           chars_nxt [KeptChars];
  logic [PosW-1:0] pos_r, pos_nxt, pos_eff;
  logic            sel_valid_r, sel_valid_nxt;
  chan_t           sel_chan_r, sel_chan_nxt;
  logic            out_valid_r;
  chan_t           out_chan_r;
  value_t          out_value_r;
  logic            emit;
  logic            adv;
  value_t          parsed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r <= '{finish: FINISH_RST, roll: ROLL_RST, pitch: PITCH_RST,
                   yaw: YAW_RST, throttle: THROTTLE_RST};
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FINISH:   codes_r.finish   <= cfg_wdata;
        REG_ROLL:     codes_r.roll     <= cfg_wdata;
        REG_PITCH:    codes_r.pitch    <= cfg_wdata;
        REG_YAW:      codes_r.yaw      <= cfg_wdata;
        REG_THROTTLE: codes_r.throttle <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    pos_eff       = (pos_r > PosWrap) ? '0 : pos_r;
    chars_nxt     = chars_r;
    pos_nxt       = pos_eff;
    sel_valid_nxt = sel_valid_r;
    sel_chan_nxt  = sel_chan_r;
    emit          = 1'b0;
    if (s1_byte_r == codes_r.finish) begin
      if (pos_eff < PosKept) begin
        chars_nxt[pos_eff[KeptIdxW-1:0]] = ASCII_NUL;
      end
      pos_nxt = '0;
      emit    = sel_valid_r;
    end else if (s1_byte_r == codes_r.roll) begin
      pos_nxt       = '0;
      sel_valid_nxt = 1'b1;
      sel_chan_nxt  = CH_ROLL;
    end else if (s1_byte_r == codes_r.pitch) begin
      pos_nxt       = '0;
      sel_valid_nxt = 1'b1;
      sel_chan_nxt  = CH_PITCH;
    end else if (s1_byte_r == codes_r.yaw) begin
      pos_nxt       = '0;
      sel_valid_nxt = 1'b1;
      sel_chan_nxt  = CH_YAW;
    end else if (s1_byte_r == codes_r.throttle) begin
      pos_nxt       = '0;
      sel_valid_nxt = 1'b1;
      sel_chan_nxt  = CH_THROTTLE;
    end else begin
      if (pos_eff < PosKept) begin
        chars_nxt[pos_eff[KeptIdxW-1:0]] = s1_byte_r;
      end
      pos_nxt = pos_eff + 1'b1;
    end
  end

  rccbp_parse u_parse (
    .chars (chars_nxt),
    .value (parsed)
  );

  assign adv           = s1_valid_r && (!out_valid_r || out_chan.ready || !emit);
  assign in_chan.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r <= in_chan.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KeptChars; i++) begin
        chars_r[i] <= '0;
      end
      pos_r       <= '0;
      sel_valid_r <= 1'b0;
      sel_chan_r  <= CH_ROLL;
    end else if (adv) begin
      chars_r     <= chars_nxt;
      pos_r       <= pos_nxt;
      sel_valid_r <= sel_valid_nxt;
      sel_chan_r  <= sel_chan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_chan_r  <= sel_chan_r;
      out_value_r <= parsed;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.channel = out_chan_r;
  assign out_chan.value   = out_value_r;

endmodule

// File: rtl/rccbp_checker.sv
// Port-level checks for rc_command_byte_parser, attached by bind.
// Depends on rccbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rccbp_checker import rccbp_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input chan_t  out_channel,
  input value_t out_value
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  `ASSERT_CLK_ALWAYS(a_reset_empties_out, !rst_n |=> !out_valid, "result after reset")
  `ASSERT_CLK(a_stall_only_from_out, !in_ready |-> out_stall, "input stall without output stall")
  `ASSERT_CLK(a_out_held, out_stall |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, out_stall |=> $stable({out_channel, out_value}), "stalled result changed")

endmodule

bind rc_command_byte_parser rccbp_checker u_rccbp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_channel (out_chan.channel),
  .out_value   (out_chan.value)
);
